/* sv/cstl_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cstl_pkg: connection slot table shared definitions
// Sizes, codes and record types used across the slot table modules.
// ----------------------------------------------------------------------------
package cstl_pkg;

    localparam int SLOTS    = 4;
    localparam int BOARDS   = 8;
    localparam int CHANNELS = 8;
    localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int MASK_W   = 8;
    localparam int IFL_W    = 4;

    // tcp port of channel 1 is 502, so the base below channel 1 is 501
    localparam logic [8:0] PORT_BELOW_CH1 = 9'd501;

    typedef enum logic [1:0] {
        KIND_ACQUIRE  = 2'd0,
        KIND_ACTIVITY = 2'd1,
        KIND_CLOSE    = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_HIT     = 3'd0,
        ST_CLAIM   = 3'd1,
        ST_EVICT   = 3'd2,
        ST_BUSY    = 3'd3,
        ST_INVALID = 3'd4,
        ST_ABSENT  = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        UPD_NONE,
        UPD_TXN_BUMP,
        UPD_CLAIM,
        UPD_STAMP,
        UPD_CLEAR
    } upd_op_t;

    typedef struct packed {
        logic        valid;
        logic [3:0]  board;
        logic [3:0]  channel;
        logic [15:0] next_txn;
        logic [31:0] last_time;
    } slot_entry_t;

    typedef struct packed {
        upd_op_t           op;
        logic [SLOT_W-1:0] slot;
        logic [3:0]        board;
        logic [3:0]        channel;
        logic [15:0]       txn_next;
        logic [31:0]       stamp;
    } slot_upd_t;

    typedef struct packed {
        status_t     status;
        logic [1:0]  slot;
        logic [15:0] txn_id;
        logic [8:0]  tcp_port;
        logic [3:0]  evicted_board;
        logic [3:0]  evicted_channel;
    } result_t;

endpackage
`default_nettype wire

/* sv/cstl_slots.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cstl_slots: slot record storage
// Holds one record per slot and applies the single update of each item.
// ----------------------------------------------------------------------------
module cstl_slots (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire cstl_pkg::slot_upd_t  upd,
    output cstl_pkg::slot_entry_t     entries [cstl_pkg::SLOTS]
);

    cstl_pkg::slot_entry_t entries_reg [cstl_pkg::SLOTS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < cstl_pkg::SLOTS; i++) begin
                entries_reg[i] <= '0;
            end
        end else begin
            for (int i = 0; i < cstl_pkg::SLOTS; i++) begin
                if (upd.slot == cstl_pkg::SLOT_W'(i)) begin
                    unique case (upd.op)
                        cstl_pkg::UPD_TXN_BUMP: begin
                            entries_reg[i].next_txn <= upd.txn_next;
                        end
                        cstl_pkg::UPD_CLAIM: begin
                            // keep last_time: a claimed slot inherits its old stamp
                            entries_reg[i].valid    <= 1'b1;
                            entries_reg[i].board    <= upd.board;
                            entries_reg[i].channel  <= upd.channel;
                            entries_reg[i].next_txn <= upd.txn_next;
                        end
                        cstl_pkg::UPD_STAMP: begin
                            entries_reg[i].last_time <= upd.stamp;
                        end
                        cstl_pkg::UPD_CLEAR: begin
                            entries_reg[i] <= '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
        end
    end

    always_comb begin
        for (int i = 0; i < cstl_pkg::SLOTS; i++) begin
            entries[i] = entries_reg[i];
        end
    end

endmodule
`default_nettype wire

/* sv/cstl_decide.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cstl_decide: per-item decision logic
// Match, free and least-recent searches over all slots, result and update.
// ----------------------------------------------------------------------------
module cstl_decide (
    input  wire logic [1:0]                   kind,
    input  wire logic [3:0]                   board,
    input  wire logic [3:0]                   channel,
    input  wire logic [3:0]                   inflight_mask,
    input  wire logic [31:0]                  now_ms,
    input  wire logic [cstl_pkg::MASK_W-1:0]  enabled_mask,
    input  wire cstl_pkg::slot_entry_t        entries [cstl_pkg::SLOTS],
    output cstl_pkg::result_t                 res,
    output cstl_pkg::slot_upd_t               upd
);

    logic [cstl_pkg::SLOTS+cstl_pkg::IFL_W-1:0] ifl_wide;
    logic [cstl_pkg::SLOTS-1:0]                 ifl;

    logic                        hit_found;
    logic [cstl_pkg::SLOT_W-1:0] hit_idx;
    logic [15:0]                 hit_txn;
    logic                        free_found;
    logic [cstl_pkg::SLOT_W-1:0] free_idx;
    logic                        lru_found;
    logic [cstl_pkg::SLOT_W-1:0] lru_idx;
    logic [31:0]                 lru_time;
    logic [3:0]                  lru_board;
    logic [3:0]                  lru_channel;
    logic                        addr_ok;
    logic [8:0]                  port;

    // slots beyond the in-flight mask never count as in flight
    assign ifl_wide = {{cstl_pkg::SLOTS{1'b0}}, inflight_mask};
    assign ifl      = ifl_wide[cstl_pkg::SLOTS-1:0];

    always_comb begin
        hit_found   = 1'b0;
        hit_idx     = '0;
        hit_txn     = '0;
        free_found  = 1'b0;
        free_idx    = '0;
        lru_found   = 1'b0;
        lru_idx     = '0;
        lru_time    = '0;
        lru_board   = '0;
        lru_channel = '0;
        for (int i = 0; i < cstl_pkg::SLOTS; i++) begin
            if (!hit_found && entries[i].valid && entries[i].board == board &&
                entries[i].channel == channel) begin
                hit_found = 1'b1;
                hit_idx   = cstl_pkg::SLOT_W'(i);
                hit_txn   = entries[i].next_txn;
            end
            if (!free_found && !entries[i].valid) begin
                free_found = 1'b1;
                free_idx   = cstl_pkg::SLOT_W'(i);
            end
            // strict compare: ties stay with the lower index
            if (!ifl[i] && (!lru_found || entries[i].last_time < lru_time)) begin
                lru_found   = 1'b1;
                lru_idx     = cstl_pkg::SLOT_W'(i);
                lru_time    = entries[i].last_time;
                lru_board   = entries[i].board;
                lru_channel = entries[i].channel;
            end
        end
    end

    always_comb begin
        addr_ok = (board >= 4'd1) && (board <= 4'(cstl_pkg::BOARDS)) &&
                  (board <= 4'(cstl_pkg::MASK_W)) &&
                  (channel >= 4'd1) && (channel <= 4'(cstl_pkg::CHANNELS));
        if (addr_ok) begin
            addr_ok = enabled_mask[3'(board - 4'd1)];
        end
    end

    assign port = cstl_pkg::PORT_BELOW_CH1 + 9'(channel);

    always_comb begin
        res          = '0;
        res.status   = cstl_pkg::ST_INVALID;
        upd          = '0;
        upd.op       = cstl_pkg::UPD_NONE;
        upd.board    = board;
        upd.channel  = channel;
        upd.stamp    = now_ms;
        case (kind) inside
            cstl_pkg::KIND_ACQUIRE: begin
                if (addr_ok) begin
                    if (hit_found) begin
                        res.status   = cstl_pkg::ST_HIT;
                        res.slot     = 2'(hit_idx);
                        res.txn_id   = hit_txn;
                        res.tcp_port = port;
                        upd.op       = cstl_pkg::UPD_TXN_BUMP;
                        upd.slot     = hit_idx;
                        upd.txn_next = hit_txn + 16'd1;
                    end else if (free_found) begin
                        res.status   = cstl_pkg::ST_CLAIM;
                        res.slot     = 2'(free_idx);
                        res.txn_id   = 16'd1;
                        res.tcp_port = port;
                        upd.op       = cstl_pkg::UPD_CLAIM;
                        upd.slot     = free_idx;
                        upd.txn_next = 16'd2;
                    end else if (lru_found) begin
                        res.status          = cstl_pkg::ST_EVICT;
                        res.slot            = 2'(lru_idx);
                        res.txn_id          = 16'd1;
                        res.tcp_port        = port;
                        res.evicted_board   = lru_board;
                        res.evicted_channel = lru_channel;
                        upd.op              = cstl_pkg::UPD_CLAIM;
                        upd.slot            = lru_idx;
                        upd.txn_next        = 16'd2;
                    end else begin
                        res.status = cstl_pkg::ST_BUSY;
                    end
                end
            end
            cstl_pkg::KIND_ACTIVITY, cstl_pkg::KIND_CLOSE: begin
                if (hit_found) begin
                    res.status = cstl_pkg::ST_HIT;
                    res.slot   = 2'(hit_idx);
                    upd.slot   = hit_idx;
                    upd.op     = (kind == cstl_pkg::KIND_ACTIVITY) ?
                                 cstl_pkg::UPD_STAMP : cstl_pkg::UPD_CLEAR;
                end else begin
                    res.status = cstl_pkg::ST_ABSENT;
                end
            end
            default: begin
                res.status = cstl_pkg::ST_INVALID;
            end
        endcase
    end

endmodule
`default_nettype wire

/* sv/connection_slot_table_lru_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// connection_slot_table_lru_core: connection slot table, least-recent eviction
// Path: an accepted item is held in the input register until the result
//   register is free or draining, then its result is loaded there.
// Throughput: one item per cycle while m_ready is high, set by the single
//   decision pass between the input register and the result register.
// Reset: synchronous aresetn clears all slot records, the board enable mask
//   and both valid flags; no clearing pass, items are taken straight away.
// ----------------------------------------------------------------------------
module connection_slot_table_lru_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration: board enable mask
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_data,
    // input items
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_kind,
    input  wire logic [3:0]  s_board,
    input  wire logic [3:0]  s_channel,
    input  wire logic [3:0]  s_inflight_mask,
    input  wire logic [31:0] s_now_ms,
    // result items
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_status,
    output logic [1:0]       m_slot,
    output logic [15:0]      m_txn_id,
    output logic [8:0]       m_tcp_port,
    output logic [3:0]       m_evicted_board,
    output logic [3:0]       m_evicted_channel
);

    logic [cstl_pkg::MASK_W-1:0] board_enabled_mask_reg;

    // input register
    logic        in_valid_reg;
    logic [1:0]  in_kind_reg;
    logic [3:0]  in_board_reg;
    logic [3:0]  in_channel_reg;
    logic [3:0]  in_inflight_reg;
    logic [31:0] in_now_reg;

    // result register
    logic              out_valid_reg;
    cstl_pkg::result_t res_reg;

    cstl_pkg::slot_entry_t entries [cstl_pkg::SLOTS];
    cstl_pkg::result_t     res;
    cstl_pkg::slot_upd_t   upd_raw;
    cstl_pkg::slot_upd_t   upd;
    logic                  advance;

    // Advance the held item when the result register is empty or being drained;
    // the slot records change on exactly that edge, so items see them in order.
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            board_enabled_mask_reg <= '0;
        end else if (cfg_valid) begin
            board_enabled_mask_reg <= cfg_data;
        end
    end

    // Capture a new item whenever the input register is free or emptying.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_kind_reg     <= s_kind;
            in_board_reg    <= s_board;
            in_channel_reg  <= s_channel;
            in_inflight_reg <= s_inflight_mask;
            in_now_reg      <= s_now_ms;
        end
    end

    cstl_decide u_decide (
        .kind          (in_kind_reg),
        .board         (in_board_reg),
        .channel       (in_channel_reg),
        .inflight_mask (in_inflight_reg),
        .now_ms        (in_now_reg),
        .enabled_mask  (board_enabled_mask_reg),
        .entries       (entries),
        .res           (res),
        .upd           (upd_raw)
    );

    // Drop the update unless the item really moves on this edge.
    always_comb begin
        upd = upd_raw;
        if (!advance) begin
            upd.op = cstl_pkg::UPD_NONE;
        end
    end

    cstl_slots u_slots (
        .aclk    (aclk),
        .aresetn (aresetn),
        .upd     (upd),
        .entries (entries)
    );

    // Hold the result until taken; load a new one on every advance.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_status          = res_reg.status;
    assign m_slot            = res_reg.slot;
    assign m_txn_id          = res_reg.txn_id;
    assign m_tcp_port        = res_reg.tcp_port;
    assign m_evicted_board   = res_reg.evicted_board;
    assign m_evicted_channel = res_reg.evicted_channel;

endmodule
`default_nettype wire

/* sv/cstl_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cstl_checker: port-level checks for the connection slot table
// Watches the result channel for reset, stall and field consistency.
// ----------------------------------------------------------------------------
module cstl_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [2:0]  m_status,
    input wire logic [1:0]  m_slot,
    input wire logic [15:0] m_txn_id,
    input wire logic [8:0]  m_tcp_port,
    input wire logic [3:0]  m_evicted_board,
    input wire logic [3:0]  m_evicted_channel
);

    // no result item survives a reset
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a stalled result item holds
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_slot) &&
            $stable(m_txn_id) && $stable(m_tcp_port))
        else $error("stalled result changed");

    // eviction fields only carry data on an eviction
    a_evict_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != cstl_pkg::ST_EVICT |->
            m_evicted_board == 4'd0 && m_evicted_channel == 4'd0)
        else $error("eviction fields set without eviction");

    // failed requests hand out nothing
    a_fail_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == cstl_pkg::ST_BUSY || m_status == cstl_pkg::ST_INVALID ||
            m_status == cstl_pkg::ST_ABSENT) |->
            m_slot == 2'd0 && m_txn_id == 16'd0 && m_tcp_port == 9'd0)
        else $error("failed request carries slot data");

    // an eviction always hands out a fresh id on a valid port
    a_evict_fresh: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == cstl_pkg::ST_EVICT |->
            m_txn_id == 16'd1 && m_tcp_port >= 9'd502 && m_tcp_port <= 9'd509)
        else $error("eviction without fresh id");

endmodule

bind connection_slot_table_lru_core cstl_checker u_cstl_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_status          (m_status),
    .m_slot            (m_slot),
    .m_txn_id          (m_txn_id),
    .m_tcp_port        (m_tcp_port),
    .m_evicted_board   (m_evicted_board),
    .m_evicted_channel (m_evicted_channel)
);
`default_nettype wire

/* bench/tb_connection_slot_table_lru_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_connection_slot_table_lru_core: self-checking bench for the slot table
// Feeds acquire, activity and close items through the valid/ready input
// channel. Each accepted item runs through a behavioural model of the table,
// and every result item is checked field by field against that model.
// Random gaps on both channels, several board enable masks, and one
// back-to-back burst on a single pair.
// ----------------------------------------------------------------------------
module tb_connection_slot_table_lru_core;

    localparam logic [8:0] TCP_PORT_CH1 = 9'd502;
    localparam int         RANDOM_PHASES = 8;
    localparam int         PHASE_ITEMS   = 250;
    localparam int         POOL_PAIRS    = 6;
    localparam int         BURST_ITEMS   = 100;
    localparam int         DRAIN_CYCLES  = 10;

    // one input item as it sits on the s_ channel
    typedef struct {
        logic [1:0]  kind;
        logic [3:0]  board;
        logic [3:0]  channel;
        logic [3:0]  inflight;
        logic [31:0] now_ms;
    } conn_item_t;

    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [7:0]  cfg_data  = 8'd0;
    logic        s_valid   = 1'b0;
    logic [1:0]  s_kind    = 2'd0;
    logic [3:0]  s_board   = 4'd0;
    logic [3:0]  s_channel = 4'd0;
    logic [3:0]  s_inflight_mask = 4'd0;
    logic [31:0] s_now_ms  = 32'd0;
    logic        m_ready   = 1'b0;
    wire logic        cfg_ready;
    wire logic        s_ready;
    wire logic        m_valid;
    wire logic [2:0]  m_status;
    wire logic [1:0]  m_slot;
    wire logic [15:0] m_txn_id;
    wire logic [8:0]  m_tcp_port;
    wire logic [3:0]  m_evicted_board;
    wire logic [3:0]  m_evicted_channel;

    // model copy of the table and of the enable register
    cstl_pkg::slot_entry_t slot_table [cstl_pkg::SLOTS];
    logic [7:0]  enable_mask = 8'd0;

    conn_item_t          pending_items [$];
    cstl_pkg::result_t   expected_results [$];
    int          error_count = 0;
    bit          calm = 1'b0;       // no idling on either side while set
    int          s_gap  = 0;
    int          m_hold = 0;

    logic [3:0]  pool_board   [POOL_PAIRS];
    logic [3:0]  pool_channel [POOL_PAIRS];
    logic [7:0]  phase_mask;
    int          phase;
    int          n;

    connection_slot_table_lru_core i_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_data          (cfg_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_kind            (s_kind),
        .s_board           (s_board),
        .s_channel         (s_channel),
        .s_inflight_mask   (s_inflight_mask),
        .s_now_ms          (s_now_ms),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_slot            (m_slot),
        .m_txn_id          (m_txn_id),
        .m_tcp_port        (m_tcp_port),
        .m_evicted_board   (m_evicted_board),
        .m_evicted_channel (m_evicted_channel)
    );

    always #1 aclk = ~aclk;

    // Idle length: mostly none, often short, now and then a long one.
    function automatic int idle_len();
        int r;
        if (calm) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Work out the result of one item and advance the model table.
    function automatic cstl_pkg::result_t resolve_item(input conn_item_t it);
        cstl_pkg::result_t r;
        int      hit;
        int      pick;
        int      i;
        r        = '0;
        r.status = cstl_pkg::ST_INVALID;
        hit      = -1;
        pick     = -1;
        for (i = 0; i < cstl_pkg::SLOTS; i++) begin
            if (hit < 0 && slot_table[i].valid && slot_table[i].board == it.board &&
                slot_table[i].channel == it.channel) begin
                hit = i;
            end
        end
        case (it.kind) inside
            cstl_pkg::KIND_ACQUIRE: begin
                // bad board, bad channel or disabled board: leave the table alone
                if (it.board >= 1 && it.board <= cstl_pkg::BOARDS && it.channel >= 1 &&
                    it.channel <= cstl_pkg::CHANNELS && enable_mask[it.board - 4'd1]) begin
                    if (hit >= 0) begin
                        pick     = hit;
                        r.status = cstl_pkg::ST_HIT;
                    end else begin
                        for (i = 0; i < cstl_pkg::SLOTS; i++) begin
                            if (pick < 0 && !slot_table[i].valid) begin
                                pick     = i;
                                r.status = cstl_pkg::ST_CLAIM;
                            end
                        end
                        if (pick < 0) begin
                            // oldest activity among slots not in flight, lowest index on ties
                            for (i = 0; i < cstl_pkg::SLOTS; i++) begin
                                if (i < cstl_pkg::IFL_W && it.inflight[i]) begin
                                    continue;
                                end
                                if (pick < 0 ||
                                    slot_table[i].last_time < slot_table[pick].last_time) begin
                                    pick = i;
                                end
                            end
                            if (pick >= 0) begin
                                r.status          = cstl_pkg::ST_EVICT;
                                r.evicted_board   = slot_table[pick].board;
                                r.evicted_channel = slot_table[pick].channel;
                            end else begin
                                r.status = cstl_pkg::ST_BUSY;
                            end
                        end
                        if (pick >= 0) begin
                            // claiming keeps the old activity time
                            slot_table[pick].valid    = 1'b1;
                            slot_table[pick].board    = it.board;
                            slot_table[pick].channel  = it.channel;
                            slot_table[pick].next_txn = 16'd1;
                        end
                    end
                    if (pick >= 0) begin
                        r.slot                    = 2'(pick);
                        r.txn_id                  = slot_table[pick].next_txn;
                        slot_table[pick].next_txn = slot_table[pick].next_txn + 16'd1;
                        r.tcp_port                = TCP_PORT_CH1 + 9'(it.channel) - 9'd1;
                    end
                end
            end
            cstl_pkg::KIND_ACTIVITY, cstl_pkg::KIND_CLOSE: begin
                if (hit >= 0) begin
                    r.status = cstl_pkg::ST_HIT;
                    r.slot   = 2'(hit);
                    if (it.kind == cstl_pkg::KIND_ACTIVITY) begin
                        slot_table[hit].last_time = it.now_ms;
                    end else begin
                        slot_table[hit] = '0;
                    end
                end else begin
                    r.status = cstl_pkg::ST_ABSENT;
                end
            end
            default: begin
                r.status = cstl_pkg::ST_INVALID;
            end
        endcase
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
            error_count++;
        end
    endtask

    task automatic add_item(input logic [1:0] kind, input logic [3:0] board,
                            input logic [3:0] channel, input logic [3:0] inflight,
                            input logic [31:0] now_ms);
        conn_item_t it;
        it.kind     = kind;
        it.board    = board;
        it.channel  = channel;
        it.inflight = inflight;
        it.now_ms   = now_ms;
        pending_items.push_back(it);
    endtask

    // Wait until the table has drained, then write the enable mask.
    task automatic write_enable_mask(input logic [7:0] value);
        @(negedge aclk);
        while (pending_items.size() != 0 || expected_results.size() != 0 || s_valid) begin
            @(negedge aclk);
        end
        repeat (4) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do begin
            @(posedge aclk);
        end while (!cfg_ready);
        enable_mask = value;
        cfg_valid  <= 1'b0;
        @(negedge aclk);
    endtask

    // Random item: mostly well-formed traffic over a small pool of pairs so
    // that hits, claims and evictions all occur; the rest is noise.
    task automatic add_random_item();
        int          r;
        int          p;
        logic [1:0]  kind;
        logic [3:0]  inflight;
        logic [31:0] now_ms;
        r = $urandom_range(0, 99);
        if (r < 85) begin
            p = $urandom_range(0, POOL_PAIRS - 1);
            r = $urandom_range(0, 99);
            kind = (r < 55) ? cstl_pkg::KIND_ACQUIRE :
                   (r < 85) ? cstl_pkg::KIND_ACTIVITY : cstl_pkg::KIND_CLOSE;
            r = $urandom_range(0, 99);
            inflight = (r < 35) ? 4'h0 : (r < 50) ? 4'hF : 4'($urandom_range(0, 15));
            // small times make ties between slots likely
            now_ms = ($urandom_range(0, 1) == 0) ? 32'($urandom_range(0, 7)) : $urandom;
            add_item(kind, pool_board[p], pool_channel[p], inflight, now_ms);
        end else begin
            add_item(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                     4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)), $urandom);
        end
    endtask

    // Driver: hold the item until accepted, predict it on acceptance, then
    // idle for a while or present the next pending item.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_gap   <= 0;
        end else begin
            if (s_valid && s_ready) begin
                expected_results.push_back(resolve_item(pending_items.pop_front()));
            end
            if (!s_valid || s_ready) begin
                if (s_gap != 0) begin
                    s_gap   <= s_gap - 1;
                    s_valid <= 1'b0;
                end else if (pending_items.size() != 0) begin
                    s_valid         <= 1'b1;
                    s_kind          <= pending_items[0].kind;
                    s_board         <= pending_items[0].board;
                    s_channel       <= pending_items[0].channel;
                    s_inflight_mask <= pending_items[0].inflight;
                    s_now_ms        <= pending_items[0].now_ms;
                    s_gap           <= idle_len();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each accepted result against the oldest expectation
    // and stall the result channel at random.
    always @(posedge aclk) begin
        cstl_pkg::result_t exp_r;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual status %0d",
                             $time, m_status);
                    error_count++;
                end else begin
                    exp_r = expected_results.pop_front();
                    check_field("status", exp_r.status, m_status);
                    check_field("slot", exp_r.slot, m_slot);
                    check_field("txn_id", exp_r.txn_id, m_txn_id);
                    check_field("tcp_port", exp_r.tcp_port, m_tcp_port);
                    check_field("evicted_board", exp_r.evicted_board, m_evicted_board);
                    check_field("evicted_channel", exp_r.evicted_channel,
                                m_evicted_channel);
                end
            end
        end
        if (m_hold != 0) begin
            m_hold  <= m_hold - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) begin
                m_hold <= idle_len();
            end
        end
    end

    // Stimulus and end of run.
    initial begin
        for (n = 0; n < cstl_pkg::SLOTS; n++) begin
            slot_table[n] = '0;
        end
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // every board disabled straight after reset
        add_item(cstl_pkg::KIND_ACQUIRE, 4'd1, 4'd1, 4'h0, 32'd0);
        add_item(cstl_pkg::KIND_ACTIVITY, 4'd1, 4'd1, 4'h0, 32'd9);

        write_enable_mask(8'hFF);
        add_item(cstl_pkg::KIND_ACQUIRE, 4'd1, 4'd1, 4'h0, 32'd0);     // claim the first slot
        add_item(cstl_pkg::KIND_ACQUIRE, 4'd1, 4'd1, 4'hF, 32'd0);     // hit, id advances
        add_item(cstl_pkg::KIND_ACQUIRE, 4'd8, 4'd8, 4'h0, 32'd0);     // top board and channel
        add_item(cstl_pkg::KIND_ACQUIRE, 4'd0, 4'd1, 4'h0, 32'd0);     // board zero
        add_item(cstl_pkg::KIND_ACQUIRE, 4'd9, 4'd1, 4'h0, 32'd0);     // board with no enable bit
        add_item(cstl_pkg::KIND_ACQUIRE, 4'd1, 4'd0, 4'h0, 32'd0);     // channel zero
        add_item(cstl_pkg::KIND_ACQUIRE, 4'd1, 4'd9, 4'h0, 32'd0);     // channel too high
        add_item(cstl_pkg::KIND_ACQUIRE, 4'd15, 4'd15, 4'hF, 32'hFFFF_FFFF);
        add_item(2'd3, 4'd1, 4'd1, 4'h0, 32'd0);                       // unknown kind
        add_item(cstl_pkg::KIND_ACTIVITY, 4'd1, 4'd1, 4'h0, 32'hFFFF_FFFF);
        add_item(cstl_pkg::KIND_ACTIVITY, 4'd2, 4'd2, 4'h0, 32'd1);    // no match
        add_item(cstl_pkg::KIND_CLOSE, 4'd3, 4'd3, 4'h0, 32'd0);       // no match
        add_item(cstl_pkg::KIND_ACQUIRE, 4'd2, 4'd3, 4'h0, 32'd0);
        add_item(cstl_pkg::KIND_ACQUIRE, 4'd4, 4'd5, 4'h0, 32'd0);     // table now full
        add_item(cstl_pkg::KIND_ACTIVITY, 4'd8, 4'd8, 4'h0, 32'd5);
        add_item(cstl_pkg::KIND_ACTIVITY, 4'd2, 4'd3, 4'h0, 32'd10);
        add_item(cstl_pkg::KIND_ACQUIRE, 4'd5, 4'd6, 4'hF, 32'd0);     // every slot in flight
        add_item(cstl_pkg::KIND_ACQUIRE, 4'd5, 4'd6, 4'h8, 32'd0);     // evict the oldest idle slot
        add_item(cstl_pkg::KIND_ACQUIRE, 4'd6, 4'd7, 4'h0, 32'd0);     // evict the never-stamped slot
        add_item(cstl_pkg::KIND_CLOSE, 4'd1, 4'd1, 4'h0, 32'd0);
        add_item(cstl_pkg::KIND_ACQUIRE, 4'd7, 4'd2, 4'h0, 32'd0);     // reuse the closed slot
        add_item(cstl_pkg::KIND_ACTIVITY, 4'd0, 4'd0, 4'h0, 32'd3);    // no address check, no match
        add_item(cstl_pkg::KIND_CLOSE, 4'd15, 4'd15, 4'h0, 32'd0);

        // back-to-back burst on one pair so that its id keeps advancing
        write_enable_mask(8'hFF);
        calm = 1'b1;
        for (n = 0; n < BURST_ITEMS; n++) begin
            add_item(cstl_pkg::KIND_ACQUIRE, 4'd1, 4'd1, 4'($urandom_range(0, 15)), 32'd0);
        end

        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0:       phase_mask = 8'h00;
                1:       phase_mask = 8'hFF;
                2:       phase_mask = 8'h01;
                3:       phase_mask = 8'h80;
                5:       phase_mask = 8'hAA;
                6:       phase_mask = 8'h55;
                default: phase_mask = 8'($urandom_range(0, 255));
            endcase
            write_enable_mask(phase_mask);
            calm = (phase == 4);
            // draw a small pool of pairs, enabled boards where there are any
            for (n = 0; n < POOL_PAIRS; n++) begin
                do begin
                    pool_board[n] = 4'($urandom_range(1, cstl_pkg::BOARDS));
                end while (enable_mask != 8'h00 && !enable_mask[pool_board[n] - 4'd1]);
                pool_channel[n] = 4'($urandom_range(1, cstl_pkg::CHANNELS));
            end
            for (n = 0; n < PHASE_ITEMS; n++) begin
                add_random_item();
            end
        end

        // drain, then allow the pipeline to settle
        @(negedge aclk);
        while (pending_items.size() != 0 || expected_results.size() != 0 || s_valid) begin
            @(negedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("connection_slot_table_lru_core verification clean");
        end else begin
            $display("connection_slot_table_lru_core verification failed");
        end
        $finish;
    end

    // Watchdog: end the run if the traffic stops moving.
    initial begin
        #2_000_000;
        $display("connection_slot_table_lru_core verification failed");
        $finish;
    end

endmodule

/* files.f */
sv/cstl_pkg.sv
sv/cstl_slots.sv
sv/cstl_decide.sv
sv/connection_slot_table_lru_core.sv
sv/cstl_checker.sv
bench/tb_connection_slot_table_lru_core.sv
